// ----- hdl/salc_pkg.sv -----
package salc_pkg;

  // Default geometry.
  localparam int AddrBitsDef  = 32;
  localparam int LineBytesDef = 16;
  localparam int SetsDef      = 16;
  localparam int WaysDef      = 4;

  // Input action codes.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_RESP  = 2'd0;
  localparam logic [1:0] KIND_MWR   = 2'd1;
  localparam logic [1:0] KIND_MRD   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // register the accepted word
    logic lookup;     // register tag compare and victim choice
    logic hit_update; // apply a hit (LRU, write, dirty)
    logic set_miss;   // record the pending miss
    logic fill_wr;    // store one fill byte
    logic install;    // install the filled line
    logic idx_clr;    // clear the byte counter
    logic idx_inc;    // advance the byte counter
    logic wb_rd;      // read the write-back byte at the counter
  } salc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       pending;
    logic       hit;
    logic       wb_needed;
    logic       idx_last;
    logic       fill_last;
  } salc_sts_t;

endpackage

// ----- hdl/set_assoc_lru_writeback_cache.sv -----
// Channel  Handshake             Word
// in       in_valid / in_ready   action, address, write_data, fill_data
// out      out_valid / out_ready kind, mem_address, data_byte, hit, last
//
// Each word is accepted in the idle state and decoded in the decode state after it.
// A hit adds a lookup and a response state. An error goes from decode to the
// response; a fill byte that ends no line goes back to idle, the last one adds
// a read state. A miss streams its memory writes, each after a read of its byte
// (one registered read port on the byte memory), then one read request per
// cycle while the output does not stall. Reset clears the per-set tag rows.
// A stalled output holds the controller in place; no new word is taken meanwhile.
module set_assoc_lru_writeback_cache #(
  parameter int ADDR_BITS  = salc_pkg::AddrBitsDef,
  parameter int LINE_BYTES = salc_pkg::LineBytesDef,
  parameter int SETS       = salc_pkg::SetsDef,
  parameter int WAYS       = salc_pkg::WaysDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  fill_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] mem_address,
  output logic [7:0]  data_byte,
  output logic        hit,
  output logic        last
);
  import salc_pkg::*;

  salc_cmd_t   cmd;
  salc_sts_t   sts;
  logic [31:0] wb_address;
  logic [31:0] rd_address;
  logic [7:0]  wb_byte;
  logic [7:0]  resp_byte;
  logic        resp_is_write;
  logic        sel_byte;

  salc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_kind(kind), .out_hit(hit), .out_last(last), .out_sel_byte(sel_byte),
    .cmd, .sts
  );

  salc_datapath #(
    .ADDR_BITS(ADDR_BITS), .LINE_BYTES(LINE_BYTES), .SETS(SETS), .WAYS(WAYS)
  ) u_dp (
    .clk, .rst, .cmd, .sts, .action, .address, .write_data, .fill_data,
    .wb_address, .rd_address, .wb_byte, .resp_byte, .resp_is_write
  );

  // Result word fields by kind.
  always_comb begin
    mem_address = '0;
    data_byte = '0;
    case (kind)
      KIND_MWR: begin
        mem_address = wb_address;
        data_byte = wb_byte;
      end
      KIND_MRD: mem_address = rd_address;
      KIND_RESP: data_byte = (resp_is_write || !sel_byte && !hit) ? 8'd0 : resp_byte;
      default: ;
    endcase
  end

  // An accepted input never coincides with a result on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output busy together");

  // An error result always ends its input.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ERROR) |-> last) else $error("error without last");

  // Only responses carry a hit.
  a_hit_resp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (kind == KIND_RESP)) else $error("hit on non-response");

endmodule

// ----- hdl/salc_datapath.sv -----
module salc_datapath #(
  parameter int ADDR_BITS  = salc_pkg::AddrBitsDef,
  parameter int LINE_BYTES = salc_pkg::LineBytesDef,
  parameter int SETS       = salc_pkg::SetsDef,
  parameter int WAYS       = salc_pkg::WaysDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  salc_pkg::salc_cmd_t   cmd,
  output salc_pkg::salc_sts_t   sts,
  input  logic [1:0]            action,
  input  logic [31:0]           address,
  input  logic [7:0]            write_data,
  input  logic [7:0]            fill_data,
  output logic [31:0]           wb_address,
  output logic [31:0]           rd_address,
  output logic [7:0]            wb_byte,
  output logic [7:0]            resp_byte,
  output logic                  resp_is_write
);
  import salc_pkg::*;

  localparam int OB    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 0;
  localparam int IB    = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int OW    = (OB > 0) ? OB : 1;
  localparam int IW    = (IB > 0) ? IB : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TW    = (ADDR_BITS - OB - IB > 0) ? ADDR_BITS - OB - IB : 1;
  localparam int NL    = SETS * WAYS;
  localparam int LW    = $clog2(NL * LINE_BYTES) > 0 ? $clog2(NL * LINE_BYTES) : 1;
  localparam int CW    = $clog2(LINE_BYTES + 1);
  localparam int EAW   = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  // Per-set tag and state rows, one entry holds all ways of a set.
  logic [WAYS-1:0][TW-1:0] tags  [SETS];
  logic [WAYS-1:0][WW-1:0] rank  [SETS];
  logic [WAYS-1:0]         vld   [SETS];
  logic [WAYS-1:0]         dirty [SETS];
  logic [7:0]    bytes_mem [NL * LINE_BYTES];

  // Captured word and pending miss.
  logic [1:0]        act;
  logic [EAW-1:0]    addr;
  logic [7:0]        wdata;
  logic [7:0]        fdata;
  logic              pending;
  logic              p_write;
  logic [WW-1:0]     way;
  logic              hit;
  logic              wb_needed;
  logic [TW-1:0]     victim_tag;
  logic [CW-1:0]     idx;
  logic [7:0]        rdata;

  logic [EAW-1:0] addr_in;
  logic [TW-1:0]  tag_c;
  logic [IW-1:0]  set_c;
  logic [OW-1:0]  off_c;

  always_comb begin
    addr_in = '0;
    addr_in[31:0] = address;
    if (ADDR_BITS < EAW) begin
      addr_in = addr_in & ((EAW'(1) << ADDR_BITS) - EAW'(1));
    end
  end

  assign tag_c = TW'(addr >> (OB + IB));
  assign set_c = (IB > 0) ? IW'(addr >> OB) : '0;
  assign off_c = (OB > 0) ? OW'(addr) : '0;

  function automatic logic [LW-1:0] line_of(logic [IW-1:0] s, logic [WW-1:0] w);
    return LW'(s * WAYS + w);
  endfunction

  // The row of the current set.
  logic [WAYS-1:0][TW-1:0] row_tags;
  logic [WAYS-1:0][WW-1:0] row_rank;
  logic [WAYS-1:0]         row_vld;
  logic [WAYS-1:0]         row_dirty;
  assign row_tags  = tags[set_c];
  assign row_rank  = rank[set_c];
  assign row_vld   = vld[set_c];
  assign row_dirty = dirty[set_c];

  // Lookup: hit search and victim choice.
  logic          h_found;
  logic [WW-1:0] h_way;
  logic          inv_found;
  logic [WW-1:0] inv_way;
  logic [WW-1:0] lru_way;
  logic [WW-1:0] best;
  logic [WW-1:0] vic;
  always_comb begin
    h_found = 1'b0;
    h_way = '0;
    inv_found = 1'b0;
    inv_way = '0;
    lru_way = '0;
    best = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!h_found && row_vld[w] && row_tags[w] == tag_c) begin
        h_found = 1'b1;
        h_way = WW'(w);
      end
      if (!inv_found && !row_vld[w]) begin
        inv_found = 1'b1;
        inv_way = WW'(w);
      end
      if (w == 0 || row_rank[w] > best) begin
        best = row_rank[w];
        lru_way = WW'(w);
      end
    end
    vic = inv_found ? inv_way : lru_way;
  end

  // Row update: LRU ranks, dirty on a write hit, and line install.
  logic          upd_en;
  logic [WW-1:0] old_rank;
  logic [WAYS-1:0][TW-1:0] row_tags_next;
  logic [WAYS-1:0][WW-1:0] row_rank_next;
  logic [WAYS-1:0]         row_vld_next;
  logic [WAYS-1:0]         row_dirty_next;
  assign upd_en   = cmd.hit_update | cmd.install;
  assign old_rank = row_vld[way] ? row_rank[way] : WW'(WAYS - 1);

  always_comb begin
    row_tags_next  = row_tags;
    row_rank_next  = row_rank;
    row_vld_next   = row_vld;
    row_dirty_next = row_dirty;
    if (upd_en) begin
      for (int w = 0; w < WAYS; w++) begin
        if (WW'(w) != way && row_vld[w] && row_rank[w] < old_rank) begin
          row_rank_next[w] = row_rank[w] + 1'b1;
        end
      end
      row_rank_next[way] = '0;
    end
    if (cmd.hit_update && act == ACT_WRITE) begin
      row_dirty_next[way] = 1'b1;
    end
    if (cmd.install) begin
      row_vld_next[way]   = 1'b1;
      row_dirty_next[way] = p_write;
      row_tags_next[way]  = tag_c;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      for (int i = 0; i < SETS; i++) begin
        vld[i]   <= '0;
        dirty[i] <= '0;
        rank[i]  <= '0;
        tags[i]  <= '0;
      end
    end else begin
      if (upd_en) begin
        vld[set_c]   <= row_vld_next;
        dirty[set_c] <= row_dirty_next;
        rank[set_c]  <= row_rank_next;
        tags[set_c]  <= row_tags_next;
      end
      if (cmd.set_miss) begin
        pending <= 1'b1;
      end
      if (cmd.install) begin
        pending <= 1'b0;
      end
    end
  end

  // Payload registers: captured word, lookup results, byte counter.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act   <= action;
      fdata <= fill_data;
      // A word taken while a miss is pending keeps the missing access.
      if (!pending) begin
        addr  <= addr_in;
        wdata <= write_data;
      end
    end
    if (cmd.lookup) begin
      hit        <= h_found;
      way        <= h_found ? h_way : vic;
      wb_needed  <= !h_found && row_vld[vic] && row_dirty[vic];
      victim_tag <= row_tags[vic];
    end
    if (cmd.set_miss) begin
      p_write <= (act == ACT_WRITE);
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Line byte memory: one write port and one registered read port.
  logic          mem_we;
  logic [LW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [LW-1:0] mem_ra;
  logic [OW-1:0] idx_off;
  assign idx_off = (OB > 0) ? OW'(idx) : '0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = LW'(line_of(set_c, way) * LINE_BYTES + off_c);
    mem_wd = wdata;
    if (cmd.hit_update && act == ACT_WRITE) begin
      mem_we = 1'b1;
    end else if (cmd.fill_wr) begin
      mem_we = 1'b1;
      mem_wa = LW'(line_of(set_c, way) * LINE_BYTES + idx_off);
      mem_wd = fdata;
    end else if (cmd.install && p_write) begin
      mem_we = 1'b1;
    end
    // Reads go to the write-back byte while streaming, else the access byte.
    // The read data holds between reads so a stalled result keeps its byte.
    mem_re = cmd.wb_rd | cmd.lookup | cmd.install;
    mem_ra = cmd.wb_rd ? LW'(line_of(set_c, way) * LINE_BYTES + idx_off)
                       : LW'(line_of(set_c, h_found ? h_way : way) * LINE_BYTES + off_c);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bytes_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= bytes_mem[mem_ra];
    end
  end

  // Status and result payload.
  logic [EAW-1:0] wb_full;
  logic [EAW-1:0] rd_full;
  always_comb begin
    wb_full = (EAW'(victim_tag) << (OB + IB)) | (EAW'(set_c) << OB) | EAW'(idx_off);
    rd_full = ((addr >> OB) << OB) | EAW'(idx_off);
  end

  assign wb_address    = wb_full[31:0];
  assign rd_address    = rd_full[31:0];
  assign wb_byte       = rdata;
  assign resp_byte     = rdata;
  assign resp_is_write = (act == ACT_WRITE) || (act == ACT_FILL && p_write);

  assign sts.action    = act;
  assign sts.pending   = pending;
  assign sts.hit       = hit;
  assign sts.wb_needed = wb_needed;
  assign sts.idx_last  = (idx == CW'(LINE_BYTES - 1));
  assign sts.fill_last = (idx == CW'(LINE_BYTES - 1));

endmodule

// ----- hdl/salc_ctrl.sv -----
module salc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic                out_hit,
  output logic                out_last,
  output logic                out_sel_byte,
  output salc_pkg::salc_cmd_t cmd,
  input  salc_pkg::salc_sts_t sts
);
  import salc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_LOOKUP, S_WB_RD, S_WB, S_REQ, S_RESP_RD, S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic [1:0] kind_next;
  logic       hit_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_WB) || (state == S_REQ) || (state == S_RESP);
  assign out_sel_byte = (state == S_WB) || (out_kind == KIND_RESP && !hit_next);

  // Next state and commands.
  always_comb begin
    cmd = '0;
    state_next = state;
    out_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.action == ACT_FILL) begin
          if (!sts.pending) begin
            state_next = S_RESP;
          end else if (sts.fill_last) begin
            cmd.fill_wr = 1'b1;
            cmd.idx_clr = 1'b1;
            state_next = S_RESP_RD;
          end else begin
            cmd.fill_wr = 1'b1;
            cmd.idx_inc = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.action != ACT_READ && sts.action != ACT_WRITE || sts.pending) begin
          state_next = S_RESP;
        end else begin
          cmd.idx_clr = 1'b1;
          cmd.lookup = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts.hit) begin
          cmd.hit_update = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.set_miss = 1'b1;
          if (sts.wb_needed) begin
            cmd.wb_rd = 1'b1;
            state_next = S_WB;
          end else begin
            state_next = S_REQ;
          end
        end
      end
      S_WB_RD: begin
        cmd.wb_rd = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        if (out_ready) begin
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_next = S_REQ;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next = S_WB_RD;
          end
        end
      end
      S_REQ: begin
        out_last = sts.idx_last;
        if (out_ready) begin
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_RESP_RD: begin
        cmd.install = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        out_last = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output kind and hit flag for the coming state.
  always_comb begin
    kind_next = out_kind;
    hit_next = out_hit;
    case (state_next)
      S_WB: begin
        kind_next = KIND_MWR;
        hit_next = 1'b0;
      end
      S_REQ: begin
        kind_next = KIND_MRD;
        hit_next = 1'b0;
      end
      S_RESP: begin
        if (state == S_DECODE) begin
          kind_next = KIND_ERROR;
          hit_next = 1'b0;
        end else if (state == S_LOOKUP) begin
          kind_next = KIND_RESP;
          hit_next = 1'b1;
        end else if (state == S_RESP_RD) begin
          kind_next = KIND_RESP;
          hit_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_kind <= KIND_RESP;
      out_hit <= 1'b0;
    end else begin
      state <= state_next;
      out_kind <= kind_next;
      out_hit <= hit_next;
    end
  end

endmodule

// ----- bench/set_assoc_lru_writeback_cache_tb.sv -----
module set_assoc_lru_writeback_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import salc_pkg::*;

  localparam logic [1:0] ACT_BAD = 2'd3;
  localparam int LINE_B = 16;
  localparam int NSETS = 16;
  localparam int NWAYS = 4;
  localparam int RANDOM_WORDS = 330;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] mem_address;
    logic [7:0]  data_byte;
    logic        hit;
    logic        last;
  } cache_result_t;

  // One row of the directed table; fill rows repeat with a rising byte.
  typedef struct {
    logic [1:0]  act;
    logic [31:0] addr;
    logic [7:0]  wd;
    logic [7:0]  fd;
    int          reps;
    bit          is_error;
  } cache_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] address;
  logic [7:0]  write_data;
  logic [7:0]  fill_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [31:0] mem_address;
  logic [7:0]  data_byte;
  logic        hit;
  logic        last;

  set_assoc_lru_writeback_cache DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the cache contents and the pending miss.
  bit          line_valid [NSETS*NWAYS];
  bit          line_dirty [NSETS*NWAYS];
  bit [23:0]   line_tag   [NSETS*NWAYS];
  bit [1:0]    lru_rank   [NSETS*NWAYS];
  bit [7:0]    line_bytes [NSETS*NWAYS*LINE_B];
  bit          miss_busy;
  bit [31:0]   miss_addr;
  bit          miss_is_write;
  bit [7:0]    miss_wbyte;
  int          miss_way;
  int          fill_idx;

  cache_result_t expected_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  bit  hold_done = 0;
  bit [23:0] tag_pool [6];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  function automatic cache_result_t mk(input logic [1:0] k, input logic [31:0] a,
                                       input logic [7:0] d, input logic h, input logic l);
    cache_result_t r;
    r.kind = k; r.mem_address = a; r.data_byte = d; r.hit = h; r.last = l;
    return r;
  endfunction

  // Make way w of set s the most recently used.
  function automatic void promote_way(input int s, input int w);
    int old;
    old = line_valid[s*NWAYS+w] ? lru_rank[s*NWAYS+w] : NWAYS-1;
    for (int v = 0; v < NWAYS; v++)
      if (v != w && line_valid[s*NWAYS+v] && lru_rank[s*NWAYS+v] < old)
        lru_rank[s*NWAYS+v]++;
    lru_rank[s*NWAYS+w] = 0;
  endfunction

  // Work out the results of one accepted word and update the shadow state.
  task automatic cache_predict(input logic [1:0] act, input logic [31:0] addr,
                               input logic [7:0] wd, input logic [7:0] fd);
    int s, ln, off, victim, best;
    bit [23:0] tg;
    bit [31:0] base;
    if (act == ACT_FILL) begin
      if (!miss_busy) begin
        expected_q.push_back(mk(KIND_ERROR, 0, 0, 0, 1));
        return;
      end
      s = miss_addr[7:4];
      ln = s*NWAYS + miss_way;
      line_bytes[ln*LINE_B + fill_idx] = fd;
      fill_idx++;
      if (fill_idx < LINE_B) return;
      off = miss_addr[3:0];
      promote_way(s, miss_way);
      line_valid[ln] = 1;
      line_tag[ln] = miss_addr[31:8];
      line_dirty[ln] = miss_is_write;
      if (miss_is_write) line_bytes[ln*LINE_B + off] = miss_wbyte;
      expected_q.push_back(mk(KIND_RESP, 0,
                              miss_is_write ? 8'd0 : line_bytes[ln*LINE_B + off], 0, 1));
      fill_idx = 0;
      miss_busy = 0;
      return;
    end
    if (act == ACT_BAD || miss_busy) begin
      expected_q.push_back(mk(KIND_ERROR, 0, 0, 0, 1));
      return;
    end
    s = addr[7:4];
    tg = addr[31:8];
    off = addr[3:0];
    for (int w = 0; w < NWAYS; w++) begin
      ln = s*NWAYS + w;
      if (line_valid[ln] && line_tag[ln] == tg) begin
        promote_way(s, w);
        if (act == ACT_WRITE) begin
          line_bytes[ln*LINE_B + off] = wd;
          line_dirty[ln] = 1;
          expected_q.push_back(mk(KIND_RESP, 0, 0, 1, 1));
        end else begin
          expected_q.push_back(mk(KIND_RESP, 0, line_bytes[ln*LINE_B + off], 1, 1));
        end
        return;
      end
    end
    // Miss: first invalid way, else the oldest one.
    victim = -1;
    for (int w = 0; w < NWAYS; w++)
      if (victim < 0 && !line_valid[s*NWAYS+w]) victim = w;
    if (victim < 0) begin
      victim = 0;
      best = 0;
      for (int w = 0; w < NWAYS; w++)
        if (w == 0 || lru_rank[s*NWAYS+w] > best) begin
          best = lru_rank[s*NWAYS+w];
          victim = w;
        end
    end
    ln = s*NWAYS + victim;
    if (line_valid[ln] && line_dirty[ln]) begin
      base = {line_tag[ln], s[3:0], 4'h0};
      for (int i = 0; i < LINE_B; i++)
        expected_q.push_back(mk(KIND_MWR, base + i, line_bytes[ln*LINE_B + i], 0, 0));
    end
    base = {addr[31:4], 4'h0};
    for (int i = 0; i < LINE_B; i++)
      expected_q.push_back(mk(KIND_MRD, base + i, 0, 0, i == LINE_B-1));
    miss_busy = 1;
    miss_addr = addr;
    miss_is_write = (act == ACT_WRITE);
    miss_wbyte = (act == ACT_WRITE) ? wd : 8'd0;
    miss_way = victim;
    fill_idx = 0;
  endtask

  // Offer one word, wait for it to be taken, then predict it.
  task automatic send_word(input logic [1:0] act, input logic [31:0] addr,
                           input logic [7:0] wd, input logic [7:0] fd, input bit is_error);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    action <= act;
    address <= addr;
    write_data <= wd;
    fill_data <= fd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    cache_predict(act, addr, wd, fd);
    // Error rows carry their answer in the table.
    if (is_error) begin
      expected_q.delete(expected_q.size() - 1);
      expected_q.push_back(mk(KIND_ERROR, 0, 0, 0, 1));
    end
  endtask

  // Receiver: random stalls, one long hold, and a stretch with none.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 11);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected word, kind", 32'(kind), 32'd0);
      end else begin
        cache_result_t e;
        e = expected_q.pop_front();
        if (kind !== e.kind) report("kind", 32'(kind), 32'(e.kind));
        if (mem_address !== e.mem_address) report("mem_address", mem_address, e.mem_address);
        if (data_byte !== e.data_byte) report("data_byte", 32'(data_byte), 32'(e.data_byte));
        if (hit !== e.hit) report("hit", 32'(hit), 32'(e.hit));
        if (last !== e.last) report("last", 32'(last), 32'(e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("set_assoc_lru_writeback_cache: mismatch");
      $finish;
    end
  end

  cache_row_t rows[$];
  logic [1:0]  r_act;
  logic [31:0] r_addr;
  int          pick;

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_READ;
    address = '0;
    write_data = '0;
    fill_data = '0;
    out_ready = 1'b0;
    miss_busy = 0;
    fill_idx = 0;
    // Directed table: errors, hit, miss, busy access, full set and dirty eviction.
    rows = '{
      '{ACT_FILL,  32'h0000_0000, 8'h00, 8'h00, 1,  1'b1},
      '{ACT_BAD,   32'hFFFF_FFFF, 8'hFF, 8'hFF, 1,  1'b1},
      '{ACT_READ,  32'h0000_0000, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_READ,  32'h0000_0005, 8'h00, 8'h00, 1,  1'b1},
      '{ACT_FILL,  32'h0000_0000, 8'h00, 8'h00, 16, 1'b0},
      '{ACT_READ,  32'h0000_000F, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'h00, 1,  1'b0},
      '{ACT_WRITE, 32'h0000_0000, 8'h55, 8'h00, 1,  1'b1},
      '{ACT_FILL,  32'h0000_0000, 8'h00, 8'hF0, 16, 1'b0},
      '{ACT_READ,  32'hFFFF_FFFF, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_WRITE, 32'hFFFF_FFF0, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_READ,  32'h0000_0FF0, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_FILL,  32'h0000_0000, 8'h00, 8'h10, 16, 1'b0},
      '{ACT_WRITE, 32'h1234_56F3, 8'hA5, 8'h00, 1,  1'b0},
      '{ACT_FILL,  32'h0000_0000, 8'h00, 8'h20, 16, 1'b0},
      '{ACT_READ,  32'h8000_00F8, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_FILL,  32'h0000_0000, 8'h00, 8'h30, 16, 1'b0},
      '{ACT_READ,  32'h0000_0FF1, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_READ,  32'hABCD_EFF2, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_FILL,  32'h0000_0000, 8'h00, 8'h40, 16, 1'b0},
      '{ACT_READ,  32'hFFFF_FFF0, 8'h00, 8'h00, 1,  1'b0},
      '{ACT_FILL,  32'h0000_0000, 8'h00, 8'h50, 16, 1'b0},
      '{ACT_READ,  32'hFFFF_FFF0, 8'h00, 8'h00, 1,  1'b0}
    };
    tag_pool[0] = 24'h000000;
    tag_pool[1] = 24'hFFFFFF;
    for (int i = 2; i < 6; i++) tag_pool[i] = 24'($urandom());
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      for (int k = 0; k < rows[i].reps; k++)
        send_word(rows[i].act, rows[i].addr, rows[i].wd, 8'(rows[i].fd + k),
                  rows[i].is_error);

    // Random part: mostly well-formed access and fill sequences, some noise.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 100) hold_req = 1;
      calm = (n >= 180 && n < 260);
      pick = $urandom_range(99);
      r_addr = $urandom();
      if ($urandom_range(9) != 0)
        r_addr = {tag_pool[$urandom_range(5)],
                  ($urandom_range(4) == 0) ? 4'($urandom()) : 4'($urandom_range(3)),
                  4'($urandom())};
      r_act = $urandom_range(1) ? ACT_WRITE : ACT_READ;
      if (miss_busy) begin
        if (pick < 92) r_act = ACT_FILL;
        else if (pick >= 96) r_act = ACT_BAD;
      end else begin
        if (pick < 4) r_act = ACT_FILL;
        else if (pick < 7) r_act = ACT_BAD;
      end
      send_word(r_act, r_addr, 8'($urandom()), 8'($urandom()), 1'b0);
    end
    // Complete any open line so the run ends idle.
    while (miss_busy) send_word(ACT_FILL, $urandom(), 8'($urandom()), 8'($urandom()), 1'b0);
    @(posedge clk);
    in_valid <= 1'b0;
    calm = 0;

    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("set_assoc_lru_writeback_cache: match");
    end else begin
      $display("set_assoc_lru_writeback_cache: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/salc_pkg.sv
hdl/salc_datapath.sv
hdl/salc_ctrl.sv
hdl/set_assoc_lru_writeback_cache.sv
bench/set_assoc_lru_writeback_cache_tb.sv
